// ===== hw/rtl/modular_multiply_assert.svh =====
// Assertion macros for the modular multiply block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef MODULAR_MULTIPLY_ASSERT_SVH
`define MODULAR_MULTIPLY_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define MM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled while in reset
`define MM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define MM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/mm_pkg.sv =====
// Shared constants and types of the modular multiply block.
// No dependencies; used by the interfaces, controller, datapath and top level.
package mm_pkg;

    localparam int OPERAND_WIDTH = 63;
    // working width of the reduction sums: up to 3*m plus a sign bit
    localparam int SUM_WIDTH     = OPERAND_WIDTH + 3;
    localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);
    localparam logic [CNT_WIDTH-1:0] CNT_INIT = CNT_WIDTH'(OPERAND_WIDTH - 1);

    typedef logic [OPERAND_WIDTH-1:0] t_word;

    typedef struct packed {
        logic load;     // capture a new word and clear the accumulator
        logic reduce;   // one bit of the multiplicand reduction
        logic last;     // final reduction bit: move the result into the base
        logic mult;     // one bit of the multiply pass
        logic emit;     // move the result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic modulus_zero;
    } t_dp_status;

endpackage

// ===== hw/rtl/mm_in_if.sv =====
// Input channel of the modular multiply block: valid/ready plus the operands.
// Depends on mm_pkg.
interface mm_in_if;
    import mm_pkg::*;

    logic  valid;
    logic  ready;
    t_word multiplicand;
    t_word multiplier;
    t_word modulus;

    modport source (output valid, output multiplicand, output multiplier,
                    output modulus, input ready);
    modport sink   (input valid, input multiplicand, input multiplier,
                    input modulus, output ready);
endinterface

// ===== hw/rtl/mm_out_if.sv =====
// Output channel of the modular multiply block: valid/ready plus the result.
// Depends on mm_pkg.
interface mm_out_if;
    import mm_pkg::*;

    logic  valid;
    logic  ready;
    t_word remainder;
    logic  zero_modulus;

    modport source (output valid, output remainder, output zero_modulus, input ready);
    modport sink   (input valid, input remainder, input zero_modulus, output ready);
endinterface

// ===== hw/rtl/mm_dpath.sv =====
// Datapath of the modular multiply block: operand registers, the add-compare
// reduction and multiply steps and the output register. Depends on mm_pkg.
module mm_dpath (
    input  logic               i_clk,
    input  mm_pkg::t_dp_cmd    i_cmd,
    output mm_pkg::t_dp_status o_status,
    input  mm_pkg::t_word      i_multiplicand,
    input  mm_pkg::t_word      i_multiplier,
    input  mm_pkg::t_word      i_modulus,
    output mm_pkg::t_word      o_remainder,
    output logic               o_zero_modulus
);
    import mm_pkg::*;

    t_word                r_a, n_a;
    t_word                r_b, n_b;
    t_word                r_acc, n_acc;
    t_word                r_base, n_base;
    t_word                r_rem, n_rem;
    logic                 r_zero, n_zero;
    logic                 r_zmod, n_zmod;
    logic [SUM_WIDTH-1:0] r_neg_m, n_neg_m;
    logic [SUM_WIDTH-1:0] r_neg_2m, n_neg_2m;

    logic [SUM_WIDTH-1:0] red_sum0, red_sum1;
    t_word                red_next;
    t_word                mul_add;
    logic [SUM_WIDTH-1:0] mul_dbl, mul_ext;
    logic [SUM_WIDTH-1:0] mul_sum0, mul_sum1, mul_sum2;
    t_word                mul_next;

    assign o_status.modulus_zero = (i_modulus == '0);

    // reduction of the multiplicand: r = 2r + bit, minus m once if it fits
    assign red_sum0 = {2'b00, r_acc, r_a[OPERAND_WIDTH-1]};
    assign red_sum1 = red_sum0 + r_neg_m;
    assign red_next = red_sum1[SUM_WIDTH-1] ? red_sum0[OPERAND_WIDTH-1:0]
                                            : red_sum1[OPERAND_WIDTH-1:0];

    // multiply step: 2*acc + bit*base lies below 3m, so take off 0, m or 2m
    assign mul_add  = r_b[OPERAND_WIDTH-1] ? r_base : '0;
    assign mul_dbl  = {2'b00, r_acc, 1'b0};
    assign mul_ext  = {3'b000, mul_add};
    assign mul_sum0 = mul_dbl + mul_ext;
    assign mul_sum1 = mul_dbl + mul_ext + r_neg_m;
    assign mul_sum2 = mul_dbl + mul_ext + r_neg_2m;

    always_comb begin
        priority if (!mul_sum2[SUM_WIDTH-1]) begin
            mul_next = mul_sum2[OPERAND_WIDTH-1:0];
        end else if (!mul_sum1[SUM_WIDTH-1]) begin
            mul_next = mul_sum1[OPERAND_WIDTH-1:0];
        end else begin
            mul_next = mul_sum0[OPERAND_WIDTH-1:0];
        end
    end

    always_comb begin
        n_a      = r_a;
        n_b      = r_b;
        n_acc    = r_acc;
        n_base   = r_base;
        n_rem    = r_rem;
        n_zero   = r_zero;
        n_zmod   = r_zmod;
        n_neg_m  = r_neg_m;
        n_neg_2m = r_neg_2m;
        if (i_cmd.load) begin
            n_a      = i_multiplicand;
            n_b      = i_multiplier;
            n_acc    = '0;
            n_zero   = o_status.modulus_zero;
            n_neg_m  = SUM_WIDTH'(0) - {3'b000, i_modulus};
            n_neg_2m = SUM_WIDTH'(0) - {2'b00, i_modulus, 1'b0};
        end
        if (i_cmd.reduce) begin
            n_a = {r_a[OPERAND_WIDTH-2:0], 1'b0};
            if (i_cmd.last) begin
                n_base = red_next;
                n_acc  = '0;
            end else begin
                n_acc = red_next;
            end
        end
        if (i_cmd.mult) begin
            n_b   = {r_b[OPERAND_WIDTH-2:0], 1'b0};
            n_acc = mul_next;
        end
        if (i_cmd.emit) begin
            n_rem  = r_zero ? '0 : r_acc;
            n_zmod = r_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_b      <= n_b;
        r_acc    <= n_acc;
        r_base   <= n_base;
        r_rem    <= n_rem;
        r_zero   <= n_zero;
        r_zmod   <= n_zmod;
        r_neg_m  <= n_neg_m;
        r_neg_2m <= n_neg_2m;
    end

    assign o_remainder    = r_rem;
    assign o_zero_modulus = r_zmod;

endmodule

// ===== hw/rtl/mm_ctrl.sv =====
// Controller of the modular multiply block: sequences the reduction and
// multiply passes and owns the output valid flag. Depends on mm_pkg.
`include "modular_multiply_assert.svh"

module mm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  mm_pkg::t_dp_status i_status,
    output mm_pkg::t_dp_cmd    o_cmd
);
    import mm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_REDUCE = 4'b0010,
        S_MULT   = 4'b0100,
        S_HOLD   = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_WIDTH-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic                 accept;
    logic                 slot_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = CNT_INIT;
                    n_state    = i_status.modulus_zero ? S_HOLD : S_REDUCE;
                end
            end
            S_REDUCE: begin
                o_cmd.reduce = 1'b1;
                o_cmd.last   = (r_cnt == '0);
                if (r_cnt == '0) begin
                    n_cnt   = CNT_INIT;
                    n_state = S_MULT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_HOLD;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_HOLD: begin
                if (slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `MM_ASSERT_NEXT(a_start_reduce, i_clk, i_rst_n, (accept && !i_status.modulus_zero), (r_state == S_REDUCE && r_cnt == CNT_INIT), "reduction did not start with a full count")
    `MM_ASSERT_NEXT(a_reduce_to_mult, i_clk, i_rst_n, (r_state == S_REDUCE && r_cnt == '0), (r_state == S_MULT && r_cnt == CNT_INIT), "multiply pass did not follow reduction")
    `MM_ASSERT_NEXT(a_mult_to_hold, i_clk, i_rst_n, (r_state == S_MULT && r_cnt == '0), (r_state == S_HOLD), "result not held after multiply pass")
    `MM_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, o_cmd.emit, (!r_out_valid || i_out_ready), "pending output word overwritten")

endmodule

// ===== hw/rtl/modular_multiply.sv =====
// Modular multiply block, top level: (a * b) mod m on unsigned operands with
// a zero-modulus flag; joins the controller and the datapath. Depends on mm_pkg,
// mm_in_if, mm_out_if, mm_ctrl and mm_dpath.
//
// Usage: each input word carries multiplicand a, multiplier b and modulus m
// (OPERAND_WIDTH bits each, unsigned) and yields exactly one output word with
// remainder = (a*b) mod m, computed exactly. A zero modulus gives remainder 0
// and zero_modulus = 1. The block works on one word at a time: for a non-zero
// modulus a word is loaded, the datapath reduces a modulo m one bit per cycle
// and then runs the multiply pass over b, one bit per cycle, and the result is
// handed over to the output register once that register is free; a zero modulus
// skips both passes and goes straight to hand-over. The result is valid in the
// cycle after the hand-over, and the next word can be accepted after it. The
// result sits in an output register, so a new word is taken while a finished
// result still waits for the sink.
`include "modular_multiply_assert.svh"

module modular_multiply (
    input logic       i_clk,
    input logic       i_rst_n,
    mm_in_if.sink     i_in,
    mm_out_if.source  o_out
);
    import mm_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencing: load, reduce pass, multiply pass, hand over to output
    mm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // operands, the reduction and multiply steps and the output word register
    mm_dpath u_dpath (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_multiplicand (i_in.multiplicand),
        .i_multiplier   (i_in.multiplier),
        .i_modulus      (i_in.modulus),
        .o_remainder    (o_out.remainder),
        .o_zero_modulus (o_out.zero_modulus)
    );

    // a zero modulus must bypass both passes and go straight to hand-over
    `MM_ASSERT_NEXT(a_zero_bypass, i_clk, i_rst_n, (i_in.valid && i_in.ready && status.modulus_zero), (!cmd.reduce && !cmd.mult), "zero modulus entered the arithmetic passes")
    // a reduction step never comes in the same cycle as a multiply, load or emit command
    `MM_ASSERT_IMP(a_one_pass, i_clk, i_rst_n, cmd.reduce, (!cmd.mult && !cmd.load && !cmd.emit), "conflicting datapath commands")
    // a flagged output word always carries a zero remainder
    `MM_ASSERT_IMP(a_zero_result, i_clk, i_rst_n, (o_out.valid && o_out.zero_modulus), (o_out.remainder == '0), "zero modulus with non-zero remainder")

endmodule

// ===== test/tb_modular_multiply.sv =====
// Self-checking testbench for modular_multiply: drives operand words through mm_in_if and
// checks every remainder and zero-modulus flag against an exact wide-product predictor.
// Depends on mm_pkg, mm_in_if, mm_out_if and the modular_multiply RTL.
module tb_modular_multiply;
    import mm_pkg::*;

    // Bounds of the run. The cycle limit allows several times the slowest legal run,
    // long hold-off included.
    localparam int RANDOM_WORDS   = 930;
    localparam int CALM_WORDS     = 100;
    localparam int HOLD_AT_WORD   = 200;
    localparam int DRAIN_AT_WORD  = 500;
    localparam int LONG_HOLD      = 700;
    localparam int END_SETTLE     = 2 * OPERAND_WIDTH + 8;
    localparam int CYCLE_LIMIT    = 800_000;

    typedef struct {
        t_word remainder;
        logic  zero_modulus;
    } t_mod_result;

    // Holds the results still owed by the block, oldest first, and predicts new ones.
    class remainder_board;
        t_mod_result awaited_remainders[$];
        int          fault_count;

        function new();
            fault_count = 0;
        endfunction

        // Exact (a*b) mod m through the full double-width product.
        function t_mod_result mod_product(t_word a, t_word b, t_word m);
            logic [2*OPERAND_WIDTH-1:0] wide_a;
            logic [2*OPERAND_WIDTH-1:0] wide_b;
            logic [2*OPERAND_WIDTH-1:0] wide_m;
            logic [2*OPERAND_WIDTH-1:0] product;
            t_mod_result r;
            wide_a = {{OPERAND_WIDTH{1'b0}}, a};
            wide_b = {{OPERAND_WIDTH{1'b0}}, b};
            wide_m = {{OPERAND_WIDTH{1'b0}}, m};
            if (m == '0) begin
                r.remainder    = '0;
                r.zero_modulus = 1'b1;
            end else begin
                product        = wide_a * wide_b;
                r.remainder    = t_word'(product % wide_m);
                r.zero_modulus = 1'b0;
            end
            return r;
        endfunction

        function void note_operands(t_word a, t_word b, t_word m);
            awaited_remainders.push_back(mod_product(a, b, m));
        endfunction

        function void check_result(t_word remainder, logic zero_modulus);
            t_mod_result want;
            if (awaited_remainders.size() == 0) begin
                $error("result word with nothing awaited: remainder %0h, zero_modulus %0b",
                       remainder, zero_modulus);
                fault_count++;
                return;
            end
            want = awaited_remainders.pop_front();
            if (remainder !== want.remainder) begin
                $error("remainder: expected %0h, got %0h", want.remainder, remainder);
                fault_count++;
            end
            if (zero_modulus !== want.zero_modulus) begin
                $error("zero_modulus: expected %0b, got %0b", want.zero_modulus, zero_modulus);
                fault_count++;
            end
        endfunction

        function int pending();
            return awaited_remainders.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    mm_in_if  in_if();
    mm_out_if out_if();

    modular_multiply dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    remainder_board board = new();

    bit calm;               // set for the closing stretch: no idling on either side
    bit hold_results_req;   // asks the sink side for one long hold-off
    int cycle_count = 0;

    always #4 i_clk = ~i_clk;

    // Abort on a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Monitors: sample both channels at the edge, before anything driven at it lands.
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready)
            board.note_operands(in_if.multiplicand, in_if.multiplier, in_if.modulus);
        if (i_rst_n && out_if.valid && out_if.ready)
            board.check_result(out_if.remainder, out_if.zero_modulus);
    end

    // Sink side: ready in random bursts, one long hold-off on request, steady once calm.
    // Each pass drives ready once and then waits at least one edge.
    initial begin : sink_side
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_results_req) begin
                // Hold off long enough for the output register and the datapath to fill,
                // so that the block has to stall its input.
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_results_req = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // Random operand: mix full-width values with small ones, near-maximum ones, single
    // bits and values of every magnitude, so that the reduction sees all bit lengths.
    function automatic t_word random_operand();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: return t_word'($urandom_range(0, 15));
            1: return '1 - t_word'($urandom_range(0, 15));
            2: return t_word'(1) << $urandom_range(0, OPERAND_WIDTH - 1);
            3: return t_word'(raw >> $urandom_range(1, 62));
            default: return t_word'(raw);
        endcase
    endfunction

    // Modulus: mostly random, now and then zero or one.
    function automatic t_word random_modulus();
        case ($urandom_range(0, 39))
            0: return '0;
            1: return t_word'(1);
            default: return random_operand();
        endcase
    endfunction

    // Offer one operand word, after an optional idle burst, and hold it until taken.
    // Valid stays high when words follow back to back.
    task automatic offer_word(input t_word a, input t_word b, input t_word m);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.multiplicand <= a;
        in_if.multiplier   <= b;
        in_if.modulus      <= m;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    // Drop valid and wait for every awaited result; the monitor has noted the last word
    // at the edge that took it.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_word full;
        t_word top_bit;
        int k;
        full    = '1;
        top_bit = t_word'(1) << (OPERAND_WIDTH - 1);

        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.multiplicand <= '0;
        in_if.multiplier   <= '0;
        in_if.modulus      <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words: zero modulus, modulus of one, operand extremes, a factor larger
        // than the modulus, single-bit values and products just around the modulus.
        offer_word('0, '0, '0);
        offer_word(full, full, '0);
        offer_word(t_word'(12345), t_word'(67890), '0);
        offer_word(full, full, t_word'(1));
        offer_word(t_word'(1), t_word'(1), t_word'(1));
        offer_word('0, full, full);
        offer_word(full, '0, full);
        offer_word(full, full, full);
        offer_word(full - 1, full - 1, full);
        offer_word(full, full, full - 1);
        offer_word(full, full, t_word'(2));
        offer_word(t_word'(1), t_word'(1), t_word'(2));
        offer_word(full, t_word'(3), t_word'(7));
        offer_word(t_word'(5), t_word'(7), full);
        offer_word(top_bit, top_bit, top_bit + 1);
        offer_word(top_bit, top_bit, top_bit);
        offer_word(top_bit - 1, full, top_bit);
        offer_word(t_word'(1), full, top_bit - 1);
        offer_word(full, t_word'(1), t_word'(1) << 31);
        offer_word(t_word'(1) << 40, t_word'(1) << 40, t_word'(1000003));

        // Random words; ask for one long hold-off on the results while words keep coming,
        // and later pause the input until the block has delivered everything.
        for (k = 0; k < RANDOM_WORDS; k++) begin
            if (k == HOLD_AT_WORD)
                hold_results_req = 1'b1;
            if (k == DRAIN_AT_WORD)
                drain_results();
            if (k == RANDOM_WORDS - CALM_WORDS)
                calm = 1'b1;
            offer_word(random_operand(), random_operand(), random_modulus());
        end

        // Let the last result arrive, then allow a further word time for stray output.
        drain_results();
        repeat (END_SETTLE) @(posedge i_clk);

        if (board.fault_count == 0 && board.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== modular_multiply.f =====
+incdir+hw/rtl
hw/rtl/mm_pkg.sv
hw/rtl/mm_in_if.sv
hw/rtl/mm_out_if.sv
hw/rtl/mm_dpath.sv
hw/rtl/mm_ctrl.sv
hw/rtl/modular_multiply.sv
test/tb_modular_multiply.sv
